### hw/rtl/process_lifecycle_table_defines.svh
// Assertion macros for the process lifecycle table checker.
// No dependencies; included by plt_checker.sv.
`ifndef PROCESS_LIFECYCLE_TABLE_DEFINES_SVH
`define PROCESS_LIFECYCLE_TABLE_DEFINES_SVH

// same-cycle implication
`define PLT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/plt_pkg.sv
// Shared codes for the process lifecycle table: actions, status, entry states.
// No dependencies; used by process_lifecycle_table and plt_checker.
package plt_pkg;

   localparam int ACT_BITS = 2;
   localparam int STS_BITS = 2;
   localparam int LS_BITS  = 2;

   localparam logic [ACT_BITS-1:0] ACT_SPAWN    = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_COMPLETE = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_READ     = 2'd2;

   localparam logic [STS_BITS-1:0] STS_OK        = 2'd0;
   localparam logic [STS_BITS-1:0] STS_FULL      = 2'd1;
   localparam logic [STS_BITS-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STS_BITS-1:0] STS_RANGE     = 2'd3;

   localparam logic [LS_BITS-1:0] LS_RUNNING   = 2'd0;
   localparam logic [LS_BITS-1:0] LS_ZOMBIE    = 2'd1;
   localparam logic [LS_BITS-1:0] LS_COMPLETED = 2'd2;
   localparam logic [LS_BITS-1:0] LS_ORPHAN    = 2'd3;

endpackage

### hw/rtl/process_lifecycle_table.sv
// Process lifecycle table: top level with the entry memory and its scan sequencer.
// Depends on plt_pkg.
//
// Use: one request beat on req_* (action, proc_id, parent_id, entry_index in
// req_tdata) gives exactly one response beat on rsp_* (status, read_id,
// read_parent, read_state, entries_used in rsp_tdata). Requests are handled
// one at a time; req_tready is high only while the sequencer is idle.
// Spawn, the unused action and a read past the count answer without a memory
// read; a read makes one memory read; complete scans the table as below.
// req_tready returns as the response is loaded into the output register.
// Complete makes two passes over the entry memory, one entry per
// cycle: the first finds the target and its parent, the second tests whether
// the parent runs and re-parents running children to 1 as orphans, writing
// back behind the read pointer; the target's new state is written last.
// The response sits in an output register; a request can be taken while a
// response waits, and its own response is held until the register frees.
// Reset (synchronous, active high) empties the table and drops any response;
// the memory itself is not cleared, entries past the count are never read.
module process_lifecycle_table
   import plt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 16,
   localparam int IDX_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1),
   localparam int REQ_BITS   = ACT_BITS + 2 * ID_BITS + IDX_BITS,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = STS_BITS + 2 * ID_BITS + LS_BITS + CNT_BITS,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // action, proc_id, parent_id, entry_index (lowest bits first), zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, read_id, read_parent, read_state, entries_used, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   typedef struct packed {
      logic [LS_BITS-1:0] life;
      logic [ID_BITS-1:0] parent;
      logic [ID_BITS-1:0] pid;
   } ent_type;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIND  = 3'd1;
   localparam logic [2:0] ST_ADOPT = 3'd2;
   localparam logic [2:0] ST_MARK  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_PUSH  = 3'd5;

   localparam logic [ID_BITS-1:0] ID_ONE  = ID_BITS'(1);
   localparam logic [ID_BITS-1:0] ID_ZERO = '0;

   // request fields
   logic [ACT_BITS-1:0] req_action;
   logic [ID_BITS-1:0]  req_proc_id;
   logic [ID_BITS-1:0]  req_parent_id;
   logic [IDX_BITS-1:0] req_entry_index;
   logic                req_beat;

   assign req_action      = req_tdata[ACT_BITS-1:0];
   assign req_proc_id     = req_tdata[ACT_BITS +: ID_BITS];
   assign req_parent_id   = req_tdata[ACT_BITS + ID_BITS +: ID_BITS];
   assign req_entry_index = req_tdata[ACT_BITS + 2 * ID_BITS +: IDX_BITS];

   // entry memory
   ent_type             entry_mem [TABLE_DEPTH];
   ent_type             rdata_ff;
   logic [IDX_BITS-1:0] mem_raddr;
   logic                mem_we;
   logic [IDX_BITS-1:0] mem_waddr;
   ent_type             mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entry_mem[mem_raddr];
   end

   // control and working registers
   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] total_ff, total_in;
   logic [CNT_BITS-1:0] ptr_ff, ptr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic                prun_ff, prun_in;
   logic [IDX_BITS-1:0] tgt_idx_ff, tgt_idx_in;
   ent_type             tgt_ent_ff, tgt_ent_in;
   logic [ID_BITS-1:0]  key_ff, key_in;
   logic [ID_BITS-1:0]  ppid_ff, ppid_in;

   // pending result
   logic [STS_BITS-1:0] res_status_ff, res_status_in;
   ent_type             res_ent_ff, res_ent_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STS_BITS-1:0] rsp_status_ff, rsp_status_in;
   ent_type             rsp_ent_ff, rsp_ent_in;
   logic [CNT_BITS-1:0] rsp_used_ff, rsp_used_in;

   logic                scan_issue;
   logic                scan_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign scan_issue = (ptr_ff < total_ff);
   assign scan_done  = !scan_issue && !rd_vld_ff;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      prun_in       = prun_ff;
      tgt_idx_in    = tgt_idx_ff;
      tgt_ent_in    = tgt_ent_ff;
      key_in        = key_ff;
      ppid_in       = ppid_ff;
      res_status_in = res_status_ff;
      res_ent_in    = res_ent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_used_in   = rsp_used_ff;
      mem_raddr     = ptr_ff[IDX_BITS-1:0];
      mem_we        = 1'b0;
      mem_waddr     = total_ff[IDX_BITS-1:0];
      mem_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               res_status_in = STS_OK;
               res_ent_in    = '0;
               key_in        = req_proc_id;
               ppid_in       = ID_ONE;
               found_in      = 1'b0;
               prun_in       = 1'b0;
               ptr_in        = '0;
               state_in      = ST_PUSH;
               case (req_action)
                  ACT_SPAWN: begin
                     if (total_ff == CNT_BITS'(TABLE_DEPTH)) begin
                        res_status_in = STS_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        mem_wdata.pid    = req_proc_id;
                        mem_wdata.life   = LS_RUNNING;
                        mem_wdata.parent = req_parent_id;
                        if (req_parent_id == ID_ZERO && req_proc_id != ID_ONE) begin
                           mem_wdata.parent = ID_ONE;
                        end
                        total_in = total_ff + CNT_BITS'(1);
                     end
                  end
                  ACT_COMPLETE: begin
                     state_in = ST_FIND;
                  end
                  ACT_READ: begin
                     if (CNT_BITS'(req_entry_index) < total_ff) begin
                        mem_raddr = req_entry_index;
                        state_in  = ST_READ;
                     end else begin
                        res_status_in = STS_RANGE;
                     end
                  end
                  default: begin
                     res_status_in = STS_OK;
                  end
               endcase
            end
         end
         ST_FIND: begin
            // first entry whose id matches gives the target and its parent
            if (scan_issue) begin
               ptr_in    = ptr_ff + CNT_BITS'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff[IDX_BITS-1:0];
            end
            if (rd_vld_ff && !found_ff && rdata_ff.pid == key_ff) begin
               found_in   = 1'b1;
               tgt_idx_in = rd_idx_ff;
               tgt_ent_in = rdata_ff;
               ppid_in    = rdata_ff.parent;
            end
            if (scan_done) begin
               ptr_in   = '0;
               state_in = ST_ADOPT;
            end
         end
         ST_ADOPT: begin
            // parent test on the states as they were; adoption writes behind
            if (scan_issue) begin
               ptr_in    = ptr_ff + CNT_BITS'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff[IDX_BITS-1:0];
            end
            if (rd_vld_ff) begin
               if (rdata_ff.pid == ppid_ff && rdata_ff.life == LS_RUNNING) begin
                  prun_in = 1'b1;
               end
               // the target itself is marked, so never adopted
               if (rdata_ff.parent == key_ff && rdata_ff.life == LS_RUNNING &&
                   !(found_ff && rd_idx_ff == tgt_idx_ff)) begin
                  mem_we           = 1'b1;
                  mem_waddr        = rd_idx_ff;
                  mem_wdata.pid    = rdata_ff.pid;
                  mem_wdata.parent = ID_ONE;
                  mem_wdata.life   = LS_ORPHAN;
               end
            end
            if (scan_done) begin
               if (found_ff) begin
                  state_in = ST_MARK;
               end else begin
                  res_status_in = STS_NOT_FOUND;
                  state_in      = ST_PUSH;
               end
            end
         end
         ST_MARK: begin
            mem_we           = 1'b1;
            mem_waddr        = tgt_idx_ff;
            mem_wdata.pid    = tgt_ent_ff.pid;
            mem_wdata.parent = tgt_ent_ff.parent;
            mem_wdata.life   = prun_ff ? LS_ZOMBIE : LS_COMPLETED;
            state_in         = ST_PUSH;
         end
         ST_READ: begin
            res_ent_in = rdata_ff;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ent_in    = res_ent_ff;
               rsp_used_in   = total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      prun_ff       <= prun_in;
      tgt_idx_ff    <= tgt_idx_in;
      tgt_ent_ff    <= tgt_ent_in;
      key_ff        <= key_in;
      ppid_ff       <= ppid_in;
      res_status_ff <= res_status_in;
      res_ent_ff    <= res_ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_used_ff, rsp_ent_ff.life, rsp_ent_ff.parent,
                               rsp_ent_ff.pid, rsp_status_ff});

endmodule

### hw/rtl/plt_checker.sv
// Port-level checker for the process lifecycle table, bound to the top level.
// Depends on plt_pkg and process_lifecycle_table_defines.svh.
`include "process_lifecycle_table_defines.svh"

module plt_checker
   import plt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 16,
   localparam int IDX_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1),
   localparam int REQ_BITS   = ACT_BITS + 2 * ID_BITS + IDX_BITS,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = STS_BITS + 2 * ID_BITS + LS_BITS + CNT_BITS,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [STS_BITS-1:0] rsp_status;
   logic [ID_BITS-1:0]  rsp_read_id;
   logic [ID_BITS-1:0]  rsp_read_parent;
   logic [LS_BITS-1:0]  rsp_read_state;
   logic [CNT_BITS-1:0] rsp_used;
   logic [ACT_BITS-1:0] req_action;

   assign rsp_status      = rsp_tdata[STS_BITS-1:0];
   assign rsp_read_id     = rsp_tdata[STS_BITS +: ID_BITS];
   assign rsp_read_parent = rsp_tdata[STS_BITS + ID_BITS +: ID_BITS];
   assign rsp_read_state  = rsp_tdata[STS_BITS + 2 * ID_BITS +: LS_BITS];
   assign rsp_used        = rsp_tdata[STS_BITS + 2 * ID_BITS + LS_BITS +: CNT_BITS];
   assign req_action      = req_tdata[ACT_BITS-1:0];

   // stalled response beat holds
   `PLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // one request at a time: taking a spawn or complete closes the input
   `PLT_ASSERT_NEXT(a_one_at_a_time, clock, reset,
      req_tvalid && req_tready && (req_action == ACT_SPAWN || req_action == ACT_COMPLETE),
      !req_tready, "request taken while busy")

   // refused spawn only with a full table
   `PLT_ASSERT_NOW(a_full_count, clock, reset, rsp_tvalid && rsp_status == STS_FULL,
      rsp_used == CNT_BITS'(TABLE_DEPTH), "table full reported below depth")

   // read fields are zero on any error status
   `PLT_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && rsp_status != STS_OK,
      rsp_read_id == '0 && rsp_read_parent == '0 && rsp_read_state == '0,
      "read fields set on error")

   // reset drops the pending response
   `PLT_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid,
      "response valid after reset")

endmodule

bind process_lifecycle_table plt_checker #(
   .TABLE_DEPTH(TABLE_DEPTH),
   .ID_BITS    (ID_BITS)
) u_plt_checker (.*);

### test/process_lifecycle_table_test.sv
// Self-checking bench for process_lifecycle_table: directed table, then random beats.
// Depends on plt_pkg and the process_lifecycle_table RTL; needs nothing else.
module process_lifecycle_table_test
   import plt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // Geometry of the block as built with its default parameters.
   localparam int DEPTH    = 64;
   localparam int REQ_W    = 40;   // 2 + 16 + 16 + 6
   localparam int RSP_W    = 48;   // 2 + 16 + 16 + 2 + 7, padded to bytes

   // The package leaves the fourth action code unnamed; the block treats it as a no-op.
   localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

   // Run shape.
   localparam int RANDOM_BEATS  = 1430;
   localparam int IDLE_PCT      = 14;    // chance per cycle that a side idles
   localparam int QUIET_FIRST   = 400;   // beat numbers with no idling on either side
   localparam int QUIET_LAST    = 600;
   localparam int HOLD_AT_RSP   = 800;   // receiver goes deaf after this many responses
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 150;   // extra wait once no response is outstanding
   localparam int STALL_LIMIT   = 3000;  // cycles with no beat on either side
   localparam int REPORT_LIMIT  = 40;

   typedef struct packed {
      logic [ACT_BITS-1:0] action;
      logic [15:0]         proc_id;
      logic [15:0]         parent_id;
      logic [5:0]          entry_index;
   } req_type;

   typedef struct packed {
      logic [STS_BITS-1:0] status;
      logic [15:0]         read_id;
      logic [15:0]         read_parent;
      logic [LS_BITS-1:0]  read_state;
      logic [6:0]          entries_used;
   } rsp_type;

   // One row of the directed table. Where typed is set, want is the hand-written answer.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // action, proc_id, parent_id, entry_index (lowest bits first)
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // status, read_id, read_parent, read_state, entries_used, zero pad
   logic [RSP_W-1:0] rsp_tdata;

   process_lifecycle_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the process table, advanced once per accepted beat.
   // ------------------------------------------------------------------
   logic [15:0]        tbl_id     [DEPTH];
   logic [15:0]        tbl_parent [DEPTH];
   logic [LS_BITS-1:0] tbl_state  [DEPTH];
   int unsigned        tbl_count = 0;

   rsp_type     expected_rsp_q [$];
   dir_row_type dir_rows [$];
   int unsigned req_sent = 0;
   int unsigned rsp_seen = 0;
   int unsigned mismatch_count = 0;

   // What the run reached, for the closing summary.
   int unsigned n_spawned = 0, n_refused = 0, n_completed_ok = 0, n_not_found = 0;
   int unsigned n_zombie = 0, n_orphaned = 0, n_read_ok = 0, n_range = 0;

   // Apply one request to the shadow table and return the response it must produce.
   function automatic rsp_type table_apply(input req_type r);
      rsp_type     o;
      logic [15:0] par;
      int unsigned tgt;
      bit          found;
      bit          par_running;
      int unsigned i;
      o = '0;
      case (r.action)
         ACT_SPAWN: begin
            if (tbl_count >= DEPTH) begin
               o.status = STS_FULL;
               n_refused++;
            end else begin
               // no parent given: init adopts it, except for init itself
               par = (r.parent_id == 16'd0 && r.proc_id != 16'd1) ? 16'd1 : r.parent_id;
               tbl_id[tbl_count]     = r.proc_id;
               tbl_parent[tbl_count] = par;
               tbl_state[tbl_count]  = LS_RUNNING;
               tbl_count++;
               n_spawned++;
            end
         end
         ACT_COMPLETE: begin
            found = 1'b0;
            tgt   = 0;
            par   = 16'd1;   // unknown id: treat as child of init
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_id[i] == r.proc_id) begin
                  found = 1'b1;
                  tgt   = i;
                  par   = tbl_parent[i];
                  break;
               end
            end
            // any running entry carrying the parent id counts, not only the first
            par_running = 1'b0;
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_id[i] == par && tbl_state[i] == LS_RUNNING) begin
                  par_running = 1'b1;
                  break;
               end
            end
            if (found) begin
               tbl_state[tgt] = par_running ? LS_ZOMBIE : LS_COMPLETED;
               n_completed_ok++;
               if (par_running)
                  n_zombie++;
            end else begin
               o.status = STS_NOT_FOUND;
               n_not_found++;
            end
            // running children are re-parented to init even when the id was not found
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_parent[i] == r.proc_id && tbl_state[i] == LS_RUNNING) begin
                  tbl_parent[i] = 16'd1;
                  tbl_state[i]  = LS_ORPHAN;
                  n_orphaned++;
               end
            end
         end
         ACT_READ: begin
            if (r.entry_index < tbl_count) begin
               o.read_id     = tbl_id[r.entry_index];
               o.read_parent = tbl_parent[r.entry_index];
               o.read_state  = tbl_state[r.entry_index];
               n_read_ok++;
            end else begin
               o.status = STS_RANGE;
               n_range++;
            end
         end
         default: ;   // unused code: nothing changes
      endcase
      o.entries_used = 7'(tbl_count);
      return o;
   endfunction

   // Ids come mostly from a small pool so that completes hit, ids repeat and
   // parent chains form; the rest covers the corners and the full 16 bits.
   function automatic logic [15:0] pick_id();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 16'($urandom_range(0, 12));
      if (roll < 75 && tbl_count != 0)
         return tbl_id[$urandom_range(0, tbl_count - 1)];
      if (roll < 85) begin
         case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'h0001;
         endcase
      end
      return 16'($urandom());
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned roll;
      // fields the action does not use still carry random bits
      r.proc_id     = 16'($urandom());
      r.parent_id   = 16'($urandom());
      r.entry_index = 6'($urandom());
      roll = $urandom_range(0, 99);
      if (tbl_count < DEPTH)
         r.action = (roll < 30) ? ACT_SPAWN : (roll < 60) ? ACT_COMPLETE :
                    (roll < 96) ? ACT_READ : ACT_UNUSED;
      else
         r.action = (roll < 8) ? ACT_SPAWN : (roll < 52) ? ACT_COMPLETE :
                    (roll < 96) ? ACT_READ : ACT_UNUSED;
      case (r.action)
         ACT_SPAWN: begin
            r.proc_id   = pick_id();
            r.parent_id = ($urandom_range(0, 99) < 30) ? 16'd0 : pick_id();
         end
         ACT_COMPLETE: begin
            if ($urandom_range(0, 99) < 60 && tbl_count != 0)
               r.proc_id = tbl_id[$urandom_range(0, tbl_count - 1)];
            else
               r.proc_id = pick_id();
         end
         ACT_READ: begin
            if ($urandom_range(0, 99) < 80 && tbl_count != 0)
               r.entry_index = 6'($urandom_range(0, tbl_count - 1));
         end
         default: ;
      endcase
      return r;
   endfunction

   // Present one request beat from a falling edge, hold it until taken, and
   // queue its expected response. Returns at the falling edge after the beat.
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (!(req_sent >= QUIET_FIRST && req_sent < QUIET_LAST) &&
             $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.entry_index, r.parent_id, r.proc_id, r.action};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = table_apply(r);
      // hand-written rows stand on their own; the shadow table still advances
      expected_rsp_q.push_back(typed ? want : predicted);
      req_sent++;
      @(negedge clock);
   endtask

   task automatic add_row(input req_type r, input bit typed, input rsp_type want);
      dir_row_type row;
      row.req   = r;
      row.typed = typed;
      row.want  = want;
      dir_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random back-pressure, one quiet stretch, one long hold-off
   // that fills the output register and blocks the request side.
   // ------------------------------------------------------------------
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= HOLD_AT_RSP) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1)
               @(negedge clock);
         end else if (rsp_seen >= QUIET_FIRST && rsp_seen < QUIET_LAST) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] response %0d: %s expected 0x%0h, got 0x%0h",
                     $time, rsp_seen, name, want, got);
      end
   endfunction

   // Response checker: every beat against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = rsp_tdata[1:0];
         got.read_id      = rsp_tdata[17:2];
         got.read_parent  = rsp_tdata[33:18];
         got.read_state   = rsp_tdata[35:34];
         got.entries_used = rsp_tdata[42:36];
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0t] response beat with nothing expected: expected none, got 0x%0h",
                        $time, rsp_tdata);
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", 16'(want.status), 16'(got.status));
            check_field("read_id", want.read_id, got.read_id);
            check_field("read_parent", want.read_parent, got.read_parent);
            check_field("read_state", 16'(want.read_state), 16'(got.read_state));
            check_field("entries_used", 16'(want.entries_used), 16'(got.entries_used));
         end
         rsp_seen++;
      end
   end

   // Watchdog: too long with no beat on either side means the block hung.
   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no beat for %0d cycles, %0d responses outstanding",
                  $time, STALL_LIMIT, expected_rsp_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      req_type     r;
      int unsigned counted;
      rsp_type     nil;
      nil = '0;

      repeat (9)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: read, complete and the unused code all see nothing.
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd0}, 1,
              '{STS_RANGE, 16'h0, 16'h0, LS_RUNNING, 7'd0});
      add_row('{ACT_COMPLETE, 16'h0005, 16'h0000, 6'd0}, 1,
              '{STS_NOT_FOUND, 16'h0, 16'h0, LS_RUNNING, 7'd0});
      add_row('{ACT_UNUSED, 16'hFFFF, 16'hFFFF, 6'd63}, 1,
              '{STS_OK, 16'h0, 16'h0, LS_RUNNING, 7'd0});
      // Build a small tree: init (keeps parent 0), a default-parented child,
      // an all-ones id, id 0, and a chain 2 -> 3 -> {4, 5}.
      add_row('{ACT_SPAWN, 16'h0001, 16'h0000, 6'd0}, 1,
              '{STS_OK, 16'h0, 16'h0, LS_RUNNING, 7'd1});
      add_row('{ACT_SPAWN, 16'h0002, 16'h0000, 6'd0}, 1,
              '{STS_OK, 16'h0, 16'h0, LS_RUNNING, 7'd2});
      add_row('{ACT_SPAWN, 16'hFFFF, 16'hFFFF, 6'd63}, 1,
              '{STS_OK, 16'h0, 16'h0, LS_RUNNING, 7'd3});
      add_row('{ACT_SPAWN, 16'h0000, 16'h0000, 6'd0}, 1,
              '{STS_OK, 16'h0, 16'h0, LS_RUNNING, 7'd4});
      add_row('{ACT_SPAWN, 16'h0003, 16'h0002, 6'd0}, 0, nil);
      add_row('{ACT_SPAWN, 16'h0004, 16'h0003, 6'd0}, 0, nil);
      add_row('{ACT_SPAWN, 16'h0005, 16'h0003, 6'd0}, 0, nil);
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd0}, 1,
              '{STS_OK, 16'h0001, 16'h0000, LS_RUNNING, 7'd7});
      add_row('{ACT_READ, 16'hFFFF, 16'hFFFF, 6'd1}, 1,
              '{STS_OK, 16'h0002, 16'h0001, LS_RUNNING, 7'd7});
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd2}, 1,
              '{STS_OK, 16'hFFFF, 16'hFFFF, LS_RUNNING, 7'd7});
      // Parent running: 3 turns zombie and its children 4, 5 become orphans.
      add_row('{ACT_COMPLETE, 16'h0003, 16'h0000, 6'd0}, 0, nil);
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd5}, 0, nil);
      add_row('{ACT_COMPLETE, 16'h0002, 16'h0000, 6'd0}, 0, nil);
      // Init's parent 0 matches the running id-0 entry, so init goes zombie,
      // and id 0 (a running child of init) is orphaned.
      add_row('{ACT_COMPLETE, 16'h0001, 16'h0000, 6'd0}, 0, nil);
      // Duplicate id: only the first entry with id 4 is marked.
      add_row('{ACT_SPAWN, 16'h0004, 16'h0001, 6'd0}, 0, nil);
      add_row('{ACT_COMPLETE, 16'h0004, 16'h0000, 6'd0}, 0, nil);
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd7}, 0, nil);
      // Unknown id still adopts its running children.
      add_row('{ACT_SPAWN, 16'h0006, 16'h00AA, 6'd0}, 0, nil);
      add_row('{ACT_COMPLETE, 16'h00AA, 16'h0000, 6'd0}, 1,
              '{STS_NOT_FOUND, 16'h0, 16'h0, LS_RUNNING, 7'd9});
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd8}, 0, nil);
      add_row('{ACT_READ, 16'h0000, 16'h0000, 6'd63}, 1,
              '{STS_RANGE, 16'h0, 16'h0, LS_RUNNING, 7'd9});

      foreach (dir_rows[k])
         send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

      // Random part; the table fills early on and stays full, so most
      // completes run the full two-pass scan.
      counted = 0;
      while (counted < RANDOM_BEATS) begin
         r = random_request();
         send_request(r, 1'b0, nil);
         counted++;
      end
      req_tvalid <= 1'b0;

      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      $display("Covered %0d requests: %0d spawns, %0d refused on a full table,",
               req_sent, n_spawned, n_refused);
      $display("  %0d reads, %0d past count; completes: %0d found (%0d zombie),",
               n_read_ok, n_range, n_completed_ok, n_zombie);
      $display("  %0d unknown ids, %0d orphans adopted; %0d mismatches.",
               n_not_found, n_orphaned, mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/plt_pkg.sv
hw/rtl/process_lifecycle_table.sv
hw/rtl/plt_checker.sv
test/process_lifecycle_table_test.sv
